// ===== hw/rtl/uvst_pkg.sv =====
// Shared types and constants for the unique value set table.
// Used by the controller, the datapath and the top level; no dependencies.
package uvst_pkg;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_COUNT    = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EXISTS    = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [4:0] occupancy;
      logic [4:0] even_total;
   } rsp_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_SCAN,
      CS_READ_LAST,
      CS_MOVE
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;
      logic       scan_en;
      logic       rd_last;
      logic       wr_insert;
      logic       wr_move;
      logic       respond;
      logic       report_evens;
      status_type rsp_status;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      opcode_type op;
      logic       fill_zero;
      logic       full;
      logic       scan_done;
      logic       match;
   } dp_status_type;

endpackage

// ===== hw/rtl/uvst_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module uvst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/uvst_datapath.sv =====
// Datapath of the set table: request latch, fill count, entry RAM, scan and response registers.
// Depends on uvst_pkg and uvst_ram.
module uvst_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  uvst_pkg::req_type        req_item,
   input  uvst_pkg::dp_cmd_type     cmd,
   output uvst_pkg::dp_status_type  sts,
   output logic                     rsp_valid,
   output uvst_pkg::rsp_type        rsp_item
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   uvst_pkg::req_type req_ff, req_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     scan_idx_ff, scan_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              match_ff, match_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [CW-1:0]     even_ff, even_in;
   logic              rsp_valid_ff, rsp_valid_in;
   uvst_pkg::rsp_type rsp_ff, rsp_in;

   logic              is_count;
   logic              scan_issue;
   logic              hit;
   logic [CW-1:0]     last_idx;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [31:0]       ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [31:0]       ram_rd_data;
   logic [CW+4:0]     occ_wide;
   logic [CW+4:0]     even_wide;

   assign is_count = (req_ff.opcode == uvst_pkg::OP_COUNT);
   assign last_idx = fill_ff - CW'(1);

   // a search stops issuing reads once a match is known; count walks every entry
   assign scan_issue = cmd.scan_en && (scan_idx_ff < fill_ff) && !(match_ff && !is_count);
   assign hit = rd_vld_ff && (ram_rd_data == req_ff.value) && !match_ff;

   assign ram_rd_en   = scan_issue | cmd.rd_last;
   assign ram_rd_addr = cmd.rd_last ? last_idx[AW-1:0] : scan_idx_ff[AW-1:0];
   assign ram_wr_en   = cmd.wr_insert | cmd.wr_move;
   assign ram_wr_addr = cmd.wr_move ? slot_ff : fill_ff[AW-1:0];
   assign ram_wr_data = cmd.wr_move ? ram_rd_data : req_ff.value;

   uvst_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      req_in       = cmd.load ? req_item : req_ff;
      scan_idx_in  = scan_idx_ff;
      rd_vld_in    = scan_issue;
      rd_idx_in    = scan_idx_ff[AW-1:0];
      match_in     = match_ff;
      slot_in      = slot_ff;
      even_in      = even_ff;
      fill_in      = fill_ff;

      if (scan_issue) begin
         scan_idx_in = scan_idx_ff + CW'(1);
      end
      if (hit) begin
         match_in = 1'b1;
         slot_in  = rd_idx_ff;
      end
      if (rd_vld_ff && !ram_rd_data[0]) begin
         even_in = even_ff + CW'(1);
      end
      if (cmd.load) begin
         scan_idx_in = '0;
         rd_vld_in   = 1'b0;
         match_in    = 1'b0;
         even_in     = '0;
      end

      if (cmd.wr_insert) begin
         fill_in = fill_ff + CW'(1);
      end else if (cmd.wr_move) begin
         fill_in = last_idx;
      end

      occ_wide  = {5'b0, fill_in};
      even_wide = {5'b0, even_ff};

      rsp_valid_in        = cmd.respond;
      rsp_in.status       = cmd.rsp_status;
      rsp_in.occupancy    = occ_wide[4:0];
      rsp_in.even_total   = cmd.report_evens ? even_wide[4:0] : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff   <= rd_idx_in;
      match_ff    <= match_in;
      slot_ff     <= slot_in;
      even_ff     <= even_in;
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      sts.op        = req_ff.opcode;
      sts.fill_zero = (fill_ff == '0);
      sts.full      = (fill_ff == CW'(CAPACITY));
      sts.match     = match_ff;
      sts.scan_done = (match_ff && !is_count) || ((scan_idx_ff == fill_ff) && !rd_vld_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_insert |-> (fill_ff < CW'(CAPACITY)) && !match_ff)
      else $error("insert into full table or over an existing value");

   a_move_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_move |-> match_ff && (fill_ff != '0))
      else $error("remove move without a match");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe longer than one cycle");

endmodule

// ===== hw/rtl/uvst_ctrl.sv =====
// Controller state machine of the set table: sequences scan, write and response steps.
// Depends on uvst_pkg.
module uvst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  uvst_pkg::dp_status_type sts,
   output uvst_pkg::dp_cmd_type    cmd
);

   uvst_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uvst_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rsp_status = uvst_pkg::ST_OK;
      busy           = (state_ff != uvst_pkg::CS_IDLE);

      case (state_ff)
         uvst_pkg::CS_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = uvst_pkg::CS_SCAN;
            end
         end
         uvst_pkg::CS_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) begin
               state_in    = uvst_pkg::CS_IDLE;
               cmd.respond = 1'b1;
               case (sts.op)
                  uvst_pkg::OP_INSERT: begin
                     if (sts.match) begin
                        cmd.rsp_status = uvst_pkg::ST_EXISTS;
                     end else if (sts.full) begin
                        cmd.rsp_status = uvst_pkg::ST_FULL;
                     end else begin
                        cmd.wr_insert = 1'b1;
                     end
                  end
                  uvst_pkg::OP_REMOVE: begin
                     if (sts.fill_zero) begin
                        cmd.rsp_status = uvst_pkg::ST_EMPTY;
                     end else if (!sts.match) begin
                        cmd.rsp_status = uvst_pkg::ST_NOT_FOUND;
                     end else begin
                        // fetch the last entry to fill the hole
                        cmd.respond = 1'b0;
                        state_in    = uvst_pkg::CS_READ_LAST;
                     end
                  end
                  uvst_pkg::OP_CONTAINS: begin
                     if (sts.fill_zero) begin
                        cmd.rsp_status = uvst_pkg::ST_EMPTY;
                     end else if (!sts.match) begin
                        cmd.rsp_status = uvst_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                     if (sts.fill_zero) begin
                        cmd.rsp_status = uvst_pkg::ST_EMPTY;
                     end else begin
                        cmd.report_evens = 1'b1;
                     end
                  end
               endcase
            end
         end
         uvst_pkg::CS_READ_LAST: begin
            cmd.rd_last = 1'b1;
            state_in    = uvst_pkg::CS_MOVE;
         end
         uvst_pkg::CS_MOVE: begin
            cmd.wr_move = 1'b1;
            cmd.respond = 1'b1;
            state_in    = uvst_pkg::CS_IDLE;
         end
         default: begin
            state_in = uvst_pkg::CS_IDLE;
         end
      endcase
   end

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but controller not busy");

   a_move_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == uvst_pkg::CS_MOVE) |-> $past(state_ff == uvst_pkg::CS_READ_LAST))
      else $error("move step without a preceding last-entry read");

   a_respond_once: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("controller still busy after responding");

endmodule

// ===== hw/rtl/unique_value_set_table_core.sv =====
// Unique value set table: distinct signed 32-bit values, searched one entry per cycle.
// A search stops at the first match, while a count walks every entry; a successful remove
// then reads the last entry and moves it into the freed slot before it responds. Busy
// drops in the strobe cycle and the next request is accepted at the edge ending it.
// Reset clears the fill count and control state; stored entries are not cleared.
// Depends on uvst_pkg, uvst_ctrl, uvst_datapath and uvst_ram; the receiver cannot stall.
module unique_value_set_table_core #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  uvst_pkg::req_type req_item,
   output logic              rsp_valid,
   output uvst_pkg::rsp_type rsp_item
);

   uvst_pkg::dp_cmd_type    cmd;
   uvst_pkg::dp_status_type sts;

   uvst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   uvst_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== tb/tb_unique_value_set_table_core.sv =====
// Testbench for unique_value_set_table_core: directed and random set requests against an
// in-bench model of the table, with every strobed result checked in order.
// Depends on uvst_pkg and the unique_value_set_table_core RTL.
module tb_unique_value_set_table_core;

   localparam int CAPACITY  = 16;
   localparam int POOL_SIZE = 24;
   localparam int MAX_GAP   = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   uvst_pkg::req_type req_item = '0;
   logic              rsp_valid;
   uvst_pkg::rsp_type rsp_item;

   // model of the table contents, updated when a request is accepted
   logic [31:0] stored_vals [CAPACITY];
   int          stored_count = 0;

   uvst_pkg::rsp_type replies_due [$];
   int                requests_sent = 0;
   int                requests_modeled = 0;
   int                bad_replies = 0;
   int                sender_idle_pct = 0;

   unique_value_set_table_core #(.CAPACITY(CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_stored(logic [31:0] v);
      int slot;
      slot = stored_count;
      for (int k = stored_count - 1; k >= 0; k--) begin
         if (stored_vals[k] == v) slot = k;
      end
      return slot;
   endfunction

   function automatic uvst_pkg::rsp_type apply_table_op(uvst_pkg::req_type r);
      uvst_pkg::rsp_type res;
      int                slot;
      int                evens;
      res.status = uvst_pkg::ST_OK;
      evens = 0;
      slot = find_stored(r.value);
      case (r.opcode)
         uvst_pkg::OP_INSERT: begin
            if (slot < stored_count) res.status = uvst_pkg::ST_EXISTS;
            else if (stored_count >= CAPACITY) res.status = uvst_pkg::ST_FULL;
            else begin
               stored_vals[stored_count] = r.value;
               stored_count++;
            end
         end
         uvst_pkg::OP_REMOVE: begin
            if (stored_count == 0) res.status = uvst_pkg::ST_EMPTY;
            else if (slot == stored_count) res.status = uvst_pkg::ST_NOT_FOUND;
            else begin
               // last entry moves into the freed slot
               stored_vals[slot] = stored_vals[stored_count - 1];
               stored_count--;
            end
         end
         uvst_pkg::OP_CONTAINS: begin
            if (stored_count == 0) res.status = uvst_pkg::ST_EMPTY;
            else if (slot == stored_count) res.status = uvst_pkg::ST_NOT_FOUND;
         end
         default: begin
            if (stored_count == 0) res.status = uvst_pkg::ST_EMPTY;
            else begin
               for (int k = 0; k < stored_count; k++) begin
                  if (stored_vals[k][0] == 1'b0) evens++;
               end
            end
         end
      endcase
      res.occupancy  = 5'(stored_count);
      res.even_total = 5'(evens);
      return res;
   endfunction

   // Results are checked before the request accepted on the same edge is modeled.
   always @(posedge clock) begin : reply_check
      uvst_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               if (bad_replies < 10)
                  $display("unexpected result: status %0d occupancy %0d evens %0d",
                           rsp_item.status, rsp_item.occupancy, rsp_item.even_total);
               bad_replies++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_item.status !== want.status || rsp_item.occupancy !== want.occupancy
                   || rsp_item.even_total !== want.even_total) begin
                  if (bad_replies < 10) begin
                     $write("mismatch: expected status %0d occupancy %0d evens %0d, ",
                            want.status, want.occupancy, want.even_total);
                     $display("got status %0d occupancy %0d evens %0d",
                              rsp_item.status, rsp_item.occupancy, rsp_item.even_total);
                  end
                  bad_replies++;
               end
            end
         end
         if (start && !busy) begin
            replies_due.insert(replies_due.size(), apply_table_op(req_item));
            requests_modeled++;
         end
      end
   end

   task automatic send_request(uvst_pkg::opcode_type op, logic [31:0] v);
      uvst_pkg::req_type item;
      int                gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.opcode = op;
      item.value  = v;
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      requests_sent++;
      // let the model catch up so the table contents can steer the next request
      wait (requests_modeled == requests_sent);
   endtask

   task automatic test_empty_set();
      send_request(uvst_pkg::OP_REMOVE, 32'd5);
      send_request(uvst_pkg::OP_CONTAINS, 32'd5);
      send_request(uvst_pkg::OP_COUNT, 32'hFFFF_FFFF);
   endtask

   task automatic test_extreme_values();
      send_request(uvst_pkg::OP_INSERT, 32'h8000_0000);
      send_request(uvst_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_request(uvst_pkg::OP_INSERT, 32'h0000_0000);
      send_request(uvst_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_request(uvst_pkg::OP_INSERT, 32'hFFFF_FFFE);
      send_request(uvst_pkg::OP_INSERT, 32'h0000_0000);
      send_request(uvst_pkg::OP_CONTAINS, 32'h8000_0000);
      send_request(uvst_pkg::OP_CONTAINS, 32'h0000_0001);
      send_request(uvst_pkg::OP_COUNT, 32'h0);
      send_request(uvst_pkg::OP_REMOVE, 32'h0000_0007);
      send_request(uvst_pkg::OP_REMOVE, 32'h8000_0000);
      send_request(uvst_pkg::OP_REMOVE, 32'hFFFF_FFFE);
      send_request(uvst_pkg::OP_COUNT, 32'h5A5A_5A5A);
      send_request(uvst_pkg::OP_CONTAINS, 32'h7FFF_FFFF);
   endtask

   task automatic test_fill_and_drain();
      while (stored_count < CAPACITY) send_request(uvst_pkg::OP_INSERT, $urandom());
      send_request(uvst_pkg::OP_INSERT, $urandom());
      send_request(uvst_pkg::OP_INSERT, stored_vals[$urandom_range(CAPACITY - 1)]);
      send_request(uvst_pkg::OP_COUNT, $urandom());
      send_request(uvst_pkg::OP_CONTAINS, stored_vals[$urandom_range(CAPACITY - 1)]);
      while (stored_count > 0) begin
         if ($urandom_range(3) == 0) send_request(uvst_pkg::OP_CONTAINS, $urandom());
         if ($urandom_range(3) == 0) send_request(uvst_pkg::OP_REMOVE, $urandom());
         send_request(uvst_pkg::OP_REMOVE, stored_vals[$urandom_range(stored_count - 1)]);
      end
      send_request(uvst_pkg::OP_REMOVE, $urandom());
      send_request(uvst_pkg::OP_CONTAINS, $urandom());
      send_request(uvst_pkg::OP_COUNT, $urandom());
   endtask

   task automatic test_random_mix(int count, int insert_pct, int remove_pct);
      logic [31:0]          value_pool [POOL_SIZE];
      logic [31:0]          v;
      int                   pick;
      uvst_pkg::opcode_type op;
      foreach (value_pool[i]) value_pool[i] = $urandom();
      repeat (count) begin
         // a small pool makes hits, duplicates and a full table common
         if ($urandom_range(7) == 0) v = $urandom();
         else v = value_pool[$urandom_range(POOL_SIZE - 1)];
         pick = $urandom_range(99);
         if (pick < insert_pct) op = uvst_pkg::OP_INSERT;
         else if (pick < insert_pct + remove_pct) op = uvst_pkg::OP_REMOVE;
         else if (pick < insert_pct + remove_pct + (100 - insert_pct - remove_pct) / 2)
            op = uvst_pkg::OP_CONTAINS;
         else op = uvst_pkg::OP_COUNT;
         send_request(op, v);
      end
   endtask

   initial begin
      int drain_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_set();
      test_extreme_values();

      sender_idle_pct = 0;
      test_fill_and_drain();
      test_random_mix(90, 45, 25);

      sender_idle_pct = 85;
      test_fill_and_drain();
      test_random_mix(90, 30, 45);

      // receiver cannot stall, so this phase only idles the sender
      sender_idle_pct = 34;
      test_fill_and_drain();
      test_random_mix(90, 40, 30);

      start <= 1'b0;
      drain_cycles = 0;
      while (replies_due.size() != 0 && drain_cycles < 500) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (CAPACITY + 8) @(posedge clock);
      if (replies_due.size() != 0) begin
         $display("%0d results never arrived", replies_due.size());
         bad_replies++;
      end
      if (bad_replies == 0) begin
         $display("PASS unique_value_set_table_core");
      end else begin
         $display("FAIL unique_value_set_table_core");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("run timed out");
      $display("FAIL unique_value_set_table_core");
      $finish;
   end

endmodule
